// File: hw/rtl/tssbf_pkg.sv
// ----------------------------------------------------------------------------
// tssbf_pkg
// Shared codes, frame offsets and controller/datapath bundles of the
// TCP SYN source blocklist filter.
// ----------------------------------------------------------------------------
package tssbf_pkg;

  // Input operation codes
  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Table response codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  // Result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_TABLE   = 1'b1;

  // Frame byte offsets
  localparam logic [6:0] POS_ETH_HI    = 7'd12;
  localparam logic [6:0] POS_ETH_LO    = 7'd13;
  localparam logic [6:0] POS_IHL       = 7'd14;
  localparam logic [6:0] POS_PROTO     = 7'd23;
  localparam logic [6:0] POS_SRC_FIRST = 7'd26;
  localparam logic [6:0] POS_SRC_LAST  = 7'd29;
  localparam logic [6:0] POS_MAX       = 7'd127;
  localparam logic [6:0] TCP_FLAG_BASE = 7'd27;  // 14 + 13
  localparam logic [7:0] MIN_FRAME     = 8'd34;
  localparam logic [3:0] IHL_MIN       = 4'd5;

  localparam logic [7:0] ETH_IPV4_HI = 8'h08;
  localparam logic [7:0] ETH_IPV4_LO = 8'h00;
  localparam logic [7:0] PROTO_TCP   = 8'd6;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic clear_wr;  // clearing pass write
    logic scan_run;  // table scan active
    logic finish;    // scan result is final
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take a result
    logic starts_scan;  // current input item needs a table scan
    logic clear_done;   // last entry cleared this cycle
    logic scan_done;    // last entry compared this cycle
  } dp_sts_t;

endpackage

// File: hw/rtl/tssbf_if.sv
// ----------------------------------------------------------------------------
// tssbf_in_if / tssbf_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tssbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  frame_byte;
  logic        end_of_frame;
  logic [31:0] table_address;

  modport source(output valid, op, frame_byte, end_of_frame, table_address, input ready);
  modport sink(input valid, op, frame_byte, end_of_frame, table_address, output ready);
endinterface

interface tssbf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        drop;
  logic [1:0]  status;
  logic [31:0] drops_so_far;

  modport source(output valid, kind, drop, status, drops_so_far, input ready);
  modport sink(input valid, kind, drop, status, drops_so_far, output ready);
endinterface

// File: hw/rtl/tssbf_ram.sv
// ----------------------------------------------------------------------------
// tssbf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tssbf_ram #(
  parameter int Width = 33,
  parameter int Depth = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                       wdata_i,
  output logic [Width-1:0]                       rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, and register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: hw/rtl/tssbf_ctrl.sv
// ----------------------------------------------------------------------------
// tssbf_ctrl
// Controller: clearing pass, idle, table scan and finish states.
// ----------------------------------------------------------------------------
module tssbf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tssbf_pkg::dp_sts_t  sts_i,
  output tssbf_pkg::ctl_cmd_t cmd_o
);
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.accept   = accept;
  assign cmd_o.clear_wr = (state_q == S_CLEAR);
  assign cmd_o.scan_run = (state_q == S_SCAN);
  assign cmd_o.finish   = (state_q == S_FIN);

  // Advance the state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clear_done) state_d = S_IDLE;
      S_IDLE:  if (accept && sts_i.starts_scan) state_d = S_SCAN;
      S_SCAN:  if (sts_i.scan_done) state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: hw/rtl/tssbf_dp.sv
// ----------------------------------------------------------------------------
// tssbf_dp
// Datapath: frame parser, table RAM with linear scan, drop counter and
// output register.
// ----------------------------------------------------------------------------
module tssbf_dp #(
  parameter int TableEntries = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tssbf_pkg::ctl_cmd_t cmd_i,
  output tssbf_pkg::dp_sts_t  sts_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          frame_byte_i,
  input  logic                end_of_frame_i,
  input  logic [31:0]         table_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_kind_o,
  output logic                out_drop_o,
  output logic [1:0]          out_status_o,
  output logic [31:0]         out_drops_so_far_o
);
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(TableEntries + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);
  localparam logic [CntW-1:0] NumEntries = CntW'(TableEntries);

  // Frame state
  logic [6:0]  pos_q;
  logic        eth_q, eth_d;
  logic [3:0]  hw_q, hw_d;
  logic        tcp_q, tcp_d;
  logic [31:0] src_q, src_d;
  logic [7:0]  flags_q, flags_d;
  logic        listed_q;
  logic [7:0]  count;
  logic [6:0]  flag_pos;
  logic        drop_frame;
  logic        frame_acc, frame_end;

  // Table state
  logic [CntW-1:0] used_q;
  logic [CntW-1:0] cnt_q;
  logic            rd_pend_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [1:0]      op_q;
  logic [31:0]     key_q;
  logic            hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [32:0]     ram_wdata, ram_rdata;
  logic            is_table_op;
  logic            ins_write, rem_write;
  logic [1:0]      tbl_status;

  // Counter and output
  logic [31:0] drop_total_q, drop_total_d;
  logic        emit;
  logic        out_valid_q;
  logic        out_kind_q, out_drop_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_total_q;

  assign frame_acc = cmd_i.accept && (op_i == tssbf_pkg::OP_FRAME);
  assign frame_end = frame_acc && end_of_frame_i;
  assign is_table_op = (op_i == tssbf_pkg::OP_INSERT) || (op_i == tssbf_pkg::OP_REMOVE);

  // Parse the current frame byte
  always_comb begin
    eth_d   = eth_q;
    hw_d    = hw_q;
    tcp_d   = tcp_q;
    src_d   = src_q;
    flags_d = flags_q;
    if (pos_q == tssbf_pkg::POS_ETH_HI) begin
      eth_d = (frame_byte_i == tssbf_pkg::ETH_IPV4_HI);
    end else if (pos_q == tssbf_pkg::POS_ETH_LO) begin
      eth_d = eth_q && (frame_byte_i == tssbf_pkg::ETH_IPV4_LO);
    end else if (pos_q == tssbf_pkg::POS_IHL) begin
      hw_d = frame_byte_i[3:0];
    end else if (pos_q == tssbf_pkg::POS_PROTO) begin
      tcp_d = (frame_byte_i == tssbf_pkg::PROTO_TCP);
    end else if (pos_q >= tssbf_pkg::POS_SRC_FIRST && pos_q <= tssbf_pkg::POS_SRC_LAST) begin
      src_d = {src_q[23:0], frame_byte_i};
    end
    flag_pos = {1'b0, hw_q, 2'b00} + tssbf_pkg::TCP_FLAG_BASE;
    if (pos_q > tssbf_pkg::POS_IHL && hw_q >= tssbf_pkg::IHL_MIN && pos_q == flag_pos) begin
      flags_d = frame_byte_i;
    end
    count = {1'b0, pos_q} + 8'd1;
    drop_frame = (count >= tssbf_pkg::MIN_FRAME) && eth_d && tcp_d
              && (hw_d >= tssbf_pkg::IHL_MIN)
              && (count >= tssbf_pkg::MIN_FRAME + {2'b00, hw_d, 2'b00})
              && flags_d[1] && !flags_d[4] && listed_q;
  end

  // Hold the frame state, clear it at the frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      eth_q    <= 1'b0;
      hw_q     <= '0;
      tcp_q    <= 1'b0;
      src_q    <= '0;
      flags_q  <= '0;
      listed_q <= 1'b0;
    end else if (frame_end) begin
      pos_q    <= '0;
      eth_q    <= 1'b0;
      hw_q     <= '0;
      tcp_q    <= 1'b0;
      src_q    <= '0;
      flags_q  <= '0;
      listed_q <= 1'b0;
    end else if (frame_acc) begin
      if (pos_q != tssbf_pkg::POS_MAX) pos_q <= pos_q + 7'd1;
      eth_q   <= eth_d;
      hw_q    <= hw_d;
      tcp_q   <= tcp_d;
      src_q   <= src_d;
      flags_q <= flags_d;
    end else if (cmd_i.finish && op_q == tssbf_pkg::OP_FRAME) begin
      listed_q <= hit_q;
    end
  end

  // Scan start: table ops, and the last source byte of an unfinished frame
  assign sts_o.starts_scan = is_table_op
                          || (op_i == tssbf_pkg::OP_FRAME && pos_q == tssbf_pkg::POS_SRC_LAST
                              && !end_of_frame_i);
  assign sts_o.clear_done  = cmd_i.clear_wr && (cnt_q[IdxW-1:0] == LastIdx);
  assign sts_o.scan_done   = rd_pend_q && (rd_idx_q == LastIdx);

  // Decide the table update at finish
  always_comb begin
    ins_write  = 1'b0;
    rem_write  = 1'b0;
    tbl_status = tssbf_pkg::STATUS_OK;
    if (op_q == tssbf_pkg::OP_INSERT) begin
      if (!hit_q) begin
        if (used_q == NumEntries) tbl_status = tssbf_pkg::STATUS_FULL;
        else ins_write = 1'b1;
      end
    end else if (op_q == tssbf_pkg::OP_REMOVE) begin
      if (hit_q) rem_write = 1'b1;
      else tbl_status = tssbf_pkg::STATUS_ABSENT;
    end
  end

  // RAM port: clearing, scan read, finish write
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cnt_q[IdxW-1:0];
    ram_wdata = '0;
    if (cmd_i.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd_i.finish) begin
      if (ins_write) begin
        ram_we    = 1'b1;
        ram_addr  = free_idx_q;
        ram_wdata = {1'b1, key_q};
      end else if (rem_write) begin
        ram_we   = 1'b1;
        ram_addr = hit_idx_q;
      end
    end
  end

  tssbf_ram #(
    .Width(33),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Scan counter, compare in the cycle after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_idx_q   <= '0;
      op_q       <= tssbf_pkg::OP_FRAME;
      key_q      <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      used_q     <= '0;
    end else begin
      if (cmd_i.clear_wr) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.accept && sts_o.starts_scan) begin
        cnt_q     <= '0;
        rd_pend_q <= 1'b0;
        op_q      <= op_i;
        key_q     <= is_table_op ? table_address_i : src_d;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
      end else if (cmd_i.scan_run) begin
        if (cnt_q < NumEntries) begin
          cnt_q     <= cnt_q + CntW'(1);
          rd_pend_q <= 1'b1;
          rd_idx_q  <= cnt_q[IdxW-1:0];
        end else begin
          rd_pend_q <= 1'b0;
        end
        if (rd_pend_q) begin
          if (ram_rdata[32] && ram_rdata[31:0] == key_q && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx_q;
          end
          if (!ram_rdata[32] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
        end
      end else if (cmd_i.finish) begin
        rd_pend_q <= 1'b0;
        if (ins_write) used_q <= used_q + CntW'(1);
        else if (rem_write) used_q <= used_q - CntW'(1);
      end
    end
  end

  // Saturating drop count
  always_comb begin
    drop_total_d = drop_total_q;
    if (frame_end && drop_frame && drop_total_q != 32'hFFFF_FFFF) begin
      drop_total_d = drop_total_q + 32'd1;
    end
  end

  assign emit = frame_end || (cmd_i.finish && op_q != tssbf_pkg::OP_FRAME);

  // Output register: load a result, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      drop_total_q <= drop_total_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q   <= frame_end ? tssbf_pkg::KIND_VERDICT : tssbf_pkg::KIND_TABLE;
      out_drop_q   <= frame_end && drop_frame;
      out_status_q <= frame_end ? tssbf_pkg::STATUS_OK : tbl_status;
      out_total_q  <= drop_total_d;
    end
  end

  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_kind_o         = out_kind_q;
  assign out_drop_o         = out_drop_q;
  assign out_status_o       = out_status_q;
  assign out_drops_so_far_o = out_total_q;
endmodule

// File: hw/rtl/tcp_syn_source_blocklist_filter_core.sv
// Filters TCP connection openings by IPv4 source address. Ethernet frames
// enter one byte per transfer; the last byte of a frame returns one verdict
// (drop or pass) with the saturating drop count. Insert and remove items
// maintain a blocklist of TABLE_ENTRIES addresses and return ok, table full
// or not present. The byte at offset 29 (last source address byte, unless it
// ends the frame) and every insert or remove start a scan of the blocklist,
// which sits in a single-port RAM that one comparator scans one entry per
// cycle; no new item is taken until the scan has finished. After reset a
// clearing pass runs before the first item is taken.
// ----------------------------------------------------------------------------
// tcp_syn_source_blocklist_filter_core
// Top level: controller, datapath and channel connections.
// ----------------------------------------------------------------------------
module tcp_syn_source_blocklist_filter_core #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tssbf_in_if.sink    in_i,
  tssbf_out_if.source out_o
);
  tssbf_pkg::ctl_cmd_t cmd;
  tssbf_pkg::dp_sts_t  sts;

  tssbf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tssbf_dp #(
    .TableEntries(TABLE_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i              (in_i.op),
    .frame_byte_i      (in_i.frame_byte),
    .end_of_frame_i    (in_i.end_of_frame),
    .table_address_i   (in_i.table_address),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_kind_o        (out_o.kind),
    .out_drop_o        (out_o.drop),
    .out_status_o      (out_o.status),
    .out_drops_so_far_o(out_o.drops_so_far)
  );
endmodule

// File: hw/rtl/tssbf_checker.sv
// ----------------------------------------------------------------------------
// tssbf_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tssbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic        out_drop_i,
  input logic [1:0]  out_status_i,
  input logic [31:0] out_drops_so_far_i
);
  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_drops_so_far_i))
    else $error("stalled result changed");

  // Verdicts carry status ok
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == tssbf_pkg::KIND_VERDICT |-> out_status_i == tssbf_pkg::STATUS_OK)
    else $error("verdict with nonzero status");

  // Table responses never drop
  a_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == tssbf_pkg::KIND_TABLE |-> !out_drop_i
      && out_status_i <= tssbf_pkg::STATUS_ABSENT)
    else $error("bad table response");

  // A dropped frame reports a nonzero count
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_drop_i |-> out_drops_so_far_i != 32'd0)
    else $error("drop with zero count");
endmodule

bind tcp_syn_source_blocklist_filter_core tssbf_checker u_tssbf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kind_i        (out_o.kind),
  .out_drop_i        (out_o.drop),
  .out_status_i      (out_o.status),
  .out_drops_so_far_i(out_o.drops_so_far)
);
